### hw/rtl/irpcr_pkg.sv
package irpcr_pkg;

    // Store depth: entries 1 .. MAX_PULSES-1 hold widths, entry 0 is unused
    localparam int MAX_PULSES = 128;

    localparam int WIDTH_W = 16;
    localparam int COUNT_W = 8;
    localparam int ADDR_W  = $clog2(MAX_PULSES);
    localparam int ENTRY_W = $clog2(MAX_PULSES + 1);
    localparam int CMP_W   = (ENTRY_W > COUNT_W) ? ENTRY_W : COUNT_W;

    // Count word written when the store fills up, saturated to the count width
    localparam logic [COUNT_W-1:0] FULL_COUNT =
        (MAX_PULSES > 255) ? COUNT_W'(255) : COUNT_W'(MAX_PULSES);

    localparam logic [WIDTH_W-1:0] TIMEOUT_RESET = WIDTH_W'(1000);

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_CAPTURE = 2'd1,
        ACT_PLAY    = 2'd2,
        ACT_SPARE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_ARMED = 2'd1,
        MODE_CAPT  = 2'd2,
        MODE_PLAY  = 2'd3
    } mode_t;

endpackage

### hw/rtl/ir_pulse_capture_replay.sv
// IR pulse-width capture and replay. One input transaction is one timebase
// tick carrying the receiver level and an action (plain tick, start capture,
// start playback); every accepted transaction yields exactly one result
// transaction, registered. A new tick can be taken every cycle while
// m_tready is high; a result held back by m_tready low stalls s_tready until
// it leaves. A capture arms on
// its start tick, waits for the first level change, then stores each interval
// between edges (in ticks) into a 128 x 16 width RAM at entries 1 onward; an
// interval reaching timeout_ticks, or a full RAM, ends it and sets the count.
// Playback drives the carrier for width 1, then toggles after each later
// width up to entry count-1. Playback of a count of 1 or less raises
// empty_error; starts while busy are ignored. The RAM has no reset and needs
// no clearing pass: playback reads only entries a capture has written.
// timeout_ticks may only be rewritten while the block is idle.
module ir_pulse_capture_replay (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,     // timeout_ticks

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,         // [1:0] action, [2] sensor_level, rest zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata          // [0] carrier_on, [1] busy_res,
                                         // [2] capture_done, [3] empty_error,
                                         // [11:4] pulse_count, rest zero
);

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    irpcr_pkg::mode_t                   mode_reg, mode_next;
    logic [irpcr_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [irpcr_pkg::ENTRY_W-1:0]      entry_reg, entry_next;
    logic [irpcr_pkg::WIDTH_W-1:0]      interval_reg, interval_next;
    logic                               prev_level_reg;
    logic                               carrier_reg, carrier_next;
    logic [irpcr_pkg::WIDTH_W-1:0]      timeout_reg;

    // Width RAM; read data always reflects the entry the next tick will use
    logic [irpcr_pkg::WIDTH_W-1:0]      width_mem [irpcr_pkg::MAX_PULSES];
    logic [irpcr_pkg::WIDTH_W-1:0]      rd_data_reg;
    logic [irpcr_pkg::ADDR_W-1:0]       rd_addr;
    logic                               wr_en;
    logic [irpcr_pkg::ADDR_W-1:0]       wr_addr;
    logic [irpcr_pkg::WIDTH_W-1:0]      wr_data;

    // Result register
    logic                               out_valid_reg;
    logic [15:0]                        out_data_reg;
    logic [15:0]                        out_data_next;

    logic                               in_accept;
    irpcr_pkg::action_t                 action;
    logic                               level;

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign action    = irpcr_pkg::action_t'(s_tdata[1:0]);
    assign level     = s_tdata[2];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------------------------------------------------------------
    // Per-tick logic
    // ---------------------------------------------------------------------
    always_comb begin
        irpcr_pkg::mode_t              m;
        logic                          edge_seen;
        logic                          just_armed;
        logic                          carrier_out, busy, done, empty;
        logic [irpcr_pkg::WIDTH_W:0]   next_ivl;
        logic [irpcr_pkg::WIDTH_W-1:0] play_w;
        logic [irpcr_pkg::ENTRY_W-1:0] entry_inc;
        logic [irpcr_pkg::WIDTH_W:0]   play_ivl;
        logic [irpcr_pkg::ENTRY_W-1:0] play_inc;

        m           = mode_reg;
        edge_seen   = (level != prev_level_reg);
        just_armed  = 1'b0;
        carrier_out = 1'b0;
        busy        = 1'b0;
        done        = 1'b0;
        empty       = 1'b0;
        next_ivl    = {1'b0, interval_reg} + 1'b1;
        play_w      = (rd_data_reg == '0) ? irpcr_pkg::WIDTH_W'(1) : rd_data_reg;
        entry_inc   = entry_reg + 1'b1;
        play_ivl    = next_ivl;
        play_inc    = entry_inc;

        count_next    = count_reg;
        entry_next    = entry_reg;
        interval_next = interval_reg;
        carrier_next  = carrier_reg;
        wr_en         = 1'b0;
        wr_addr       = entry_reg[irpcr_pkg::ADDR_W-1:0];
        wr_data       = next_ivl[irpcr_pkg::WIDTH_W-1:0];

        if (m == irpcr_pkg::MODE_IDLE) begin
            if (action == irpcr_pkg::ACT_CAPTURE) begin
                m          = irpcr_pkg::MODE_ARMED;
                just_armed = 1'b1;
            end else if (action == irpcr_pkg::ACT_PLAY) begin
                if (count_reg <= irpcr_pkg::COUNT_W'(1)) begin
                    empty = 1'b1;
                end else begin
                    m             = irpcr_pkg::MODE_PLAY;
                    carrier_next  = 1'b1;
                    entry_next    = irpcr_pkg::ENTRY_W'(1);
                    interval_next = '0;
                end
            end
        end

        unique case (m)
            irpcr_pkg::MODE_IDLE: begin
            end
            irpcr_pkg::MODE_ARMED: begin
                busy = 1'b1;
                if (!just_armed && edge_seen) begin
                    m             = irpcr_pkg::MODE_CAPT;
                    entry_next    = irpcr_pkg::ENTRY_W'(1);
                    interval_next = '0;
                end
            end
            irpcr_pkg::MODE_CAPT: begin
                busy = 1'b1;
                // timeout wins over an edge on the same tick
                if (next_ivl >= {1'b0, timeout_reg}) begin
                    wr_en      = 1'b1;
                    wr_data    = timeout_reg;
                    count_next = entry_reg[irpcr_pkg::COUNT_W-1:0];
                    m          = irpcr_pkg::MODE_IDLE;
                    done       = 1'b1;
                end else if (edge_seen) begin
                    wr_en         = 1'b1;
                    interval_next = '0;
                    entry_next    = entry_inc;
                    if (entry_inc >= irpcr_pkg::ENTRY_W'(irpcr_pkg::MAX_PULSES)) begin
                        count_next = irpcr_pkg::FULL_COUNT;
                        m          = irpcr_pkg::MODE_IDLE;
                        done       = 1'b1;
                    end
                end else begin
                    interval_next = next_ivl[irpcr_pkg::WIDTH_W-1:0];
                end
            end
            irpcr_pkg::MODE_PLAY: begin
                // the start tick already counts as the first tick of width 1
                play_ivl    = {1'b0, interval_next} + 1'b1;
                play_inc    = entry_next + 1'b1;
                busy        = 1'b1;
                carrier_out = carrier_next;
                if (play_ivl >= {1'b0, play_w}) begin
                    entry_next    = play_inc;
                    interval_next = '0;
                    if (irpcr_pkg::CMP_W'(play_inc) >= irpcr_pkg::CMP_W'(count_reg)) begin
                        carrier_next = 1'b0;
                        m            = irpcr_pkg::MODE_IDLE;
                    end else begin
                        carrier_next = !carrier_next;
                    end
                end else begin
                    interval_next = play_ivl[irpcr_pkg::WIDTH_W-1:0];
                end
            end
            default: begin
            end
        endcase

        mode_next     = m;
        out_data_next = {4'b0000, count_next, empty, done, busy, carrier_out};

        // Capture and playback state does not change on cycles without a transaction
        if (!in_accept) begin
            mode_next     = mode_reg;
            count_next    = count_reg;
            entry_next    = entry_reg;
            interval_next = interval_reg;
            carrier_next  = carrier_reg;
            wr_en         = 1'b0;
        end

        // Outside playback keep entry 1 prefetched for a playback start
        if (mode_next == irpcr_pkg::MODE_PLAY) begin
            rd_addr = entry_next[irpcr_pkg::ADDR_W-1:0];
        end else begin
            rd_addr = irpcr_pkg::ADDR_W'(1);
        end
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= irpcr_pkg::MODE_IDLE;
            count_reg      <= '0;
            entry_reg      <= '0;
            interval_reg   <= '0;
            prev_level_reg <= 1'b1;
            carrier_reg    <= 1'b0;
            timeout_reg    <= irpcr_pkg::TIMEOUT_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            entry_reg    <= entry_next;
            interval_reg <= interval_next;
            carrier_reg  <= carrier_next;
            if (in_accept) begin
                prev_level_reg <= level;
            end
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (in_accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_data_reg <= out_data_next;
        end
    end

    // Width RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            width_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= width_mem[rd_addr];
    end

endmodule
